// ===== hdl/int_to_padded_decimal_text_defines.svh =====
// assertion macros used by the checker of the decimal text block
// no dependencies; take in by include before the modules that assert
`ifndef INT_TO_PADDED_DECIMAL_TEXT_DEFINES_SVH
`define INT_TO_PADDED_DECIMAL_TEXT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ITPDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("itpdt assertion failed");

// next-cycle implication, disabled in reset
`define ITPDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("itpdt assertion failed");

`endif

// ===== hdl/itpdt_pkg.sv =====
// shared types, constants and the bcd adjust function of the decimal text block
// no dependencies
package itpdt_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CONV_STEPS = VALUE_W;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);
    localparam int CFG_W      = 5;

    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take a new request
        logic step;   // one shift-add conversion step
        logic size;   // count digits and set up the field
        logic emit;   // load the next character into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_char;  // the character about to be emitted ends the text
    } t_status;

    // add 3 to every bcd digit that is 5 or more
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] res;
        logic [3:0]       nib;
        res = b;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            nib = b[4*i +: 4];
            if (nib >= 4'd5) begin
                res[4*i +: 4] = nib + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/int_to_padded_decimal_text.sv =====
// top level of the decimal text block: controller plus datapath
// depends on itpdt_pkg, itpdt_ctrl, itpdt_dp
//
// Converts each signed 32-bit request to right-justified decimal ASCII, one
// character per output request, most significant first, with o_last on the
// final digit. Blanks pad on the left up to i_cfg_data as last written
// (reset 0), saturated at MAX_WIDTH. Each item goes through an accept step, the
// 32 shift-add steps of the double dabble converter and a sizing step, then one
// character per cycle into the output register while the output is not stalled.
// The next request is taken as soon as the final character is in that register.
// Write the width only while the block is idle.
module int_to_padded_decimal_text #(
    parameter int MAX_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [31:0]   i_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_char_code,
    output logic                 o_last
);

    itpdt_pkg::t_cmd    cmd;
    itpdt_pkg::t_status status;

    // sequencing
    itpdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // conversion and character generation
    itpdt_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

// ===== hdl/itpdt_ctrl.sv =====
// controller of the decimal text block: accept, convert, size, emit sequence
// depends on itpdt_pkg
module itpdt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  itpdt_pkg::t_status i_status,
    output itpdt_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [itpdt_pkg::STEP_CNT_W-1:0] r_step, n_step;
    logic                             r_out_valid, n_out_valid;
    itpdt_pkg::t_cmd                  cmd;
    logic                             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_step   = '0;
                    n_state  = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                n_step   = r_step + 1'b1;
                if (r_step == itpdt_pkg::STEP_CNT_W'(itpdt_pkg::CONV_STEPS - 1)) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                cmd.size = 1'b1;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    if (i_status.last_char) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hdl/itpdt_dp.sv =====
// datapath of the decimal text block: width register, double dabble, character output
// depends on itpdt_pkg
module itpdt_dp #(
    parameter int MAX_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [itpdt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic signed [itpdt_pkg::VALUE_W-1:0] i_value,
    input  itpdt_pkg::t_cmd                 i_cmd,
    output itpdt_pkg::t_status              o_status,
    output logic [7:0]                      o_char_code,
    output logic                            o_last
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (CW > itpdt_pkg::CFG_W) ? CW : itpdt_pkg::CFG_W;

    logic [itpdt_pkg::CFG_W-1:0]   r_min_width;
    logic [itpdt_pkg::VALUE_W-1:0] r_mag;
    logic [itpdt_pkg::BCD_W-1:0]   r_bcd;
    logic                          r_neg;
    logic [3:0]                    r_text_len;
    logic [CW-1:0]                 r_remain;
    logic [7:0]                    r_char;
    logic                          r_last;

    logic [itpdt_pkg::BCD_W-1:0]   bcd_adj;
    logic [3:0]                    num_digits;
    logic [3:0]                    text_len;
    logic [CMPW-1:0]               width_c;
    logic [CW-1:0]                 width_eff;
    logic [CW-1:0]                 text_len_c;
    logic [CW-1:0]                 total;
    logic [CW-1:0]                 remain_m1;
    logic [CW-1:0]                 cur_len;
    logic [3:0]                    digit;
    logic [7:0]                    char_next;

    // configured width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= '0;
        end else if (i_cfg_we) begin
            r_min_width <= i_cfg_data;
        end
    end

    assign bcd_adj = itpdt_pkg::bcd_adjust(r_bcd);

    // digit count: position of the highest nonzero digit, at least one
    always_comb begin
        num_digits = 4'd1;
        for (int i = 1; i < itpdt_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                num_digits = 4'(i + 1);
            end
        end
    end

    // field size: text length against the saturated width
    always_comb begin
        text_len   = num_digits + {3'd0, r_neg};
        text_len_c = CW'(text_len);
        if (CMPW'(r_min_width) > CMPW'(MAX_WIDTH)) begin
            width_c = CMPW'(MAX_WIDTH);
        end else begin
            width_c = CMPW'(r_min_width);
        end
        width_eff = width_c[CW-1:0];
        total     = (width_eff > text_len_c) ? width_eff : text_len_c;
    end

    // character at the current countdown position
    always_comb begin
        cur_len   = CW'(r_text_len);
        remain_m1 = r_remain - 1'b1;
        digit     = 4'd0;
        for (int i = 0; i < itpdt_pkg::NUM_DIGITS; i++) begin
            if (remain_m1[3:0] == 4'(i)) begin
                digit = r_bcd[4*i +: 4];
            end
        end
        if (r_remain > cur_len) begin
            char_next = itpdt_pkg::CH_BLANK;
        end else if (r_neg && (r_remain == cur_len)) begin
            char_next = itpdt_pkg::CH_MINUS;
        end else begin
            char_next = itpdt_pkg::CH_ZERO + {4'd0, digit};
        end
    end

    // conversion and emission registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[itpdt_pkg::VALUE_W-1];
            r_mag <= i_value[itpdt_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            r_bcd <= '0;
        end
        if (i_cmd.step) begin
            r_bcd <= {bcd_adj[itpdt_pkg::BCD_W-2:0], r_mag[itpdt_pkg::VALUE_W-1]};
            r_mag <= {r_mag[itpdt_pkg::VALUE_W-2:0], 1'b0};
        end
        if (i_cmd.size) begin
            r_text_len <= text_len;
            r_remain   <= total;
        end
        if (i_cmd.emit) begin
            r_char   <= char_next;
            r_last   <= (r_remain == CW'(1));
            r_remain <= remain_m1;
        end
    end

    assign o_status.last_char = (r_remain == CW'(1));
    assign o_char_code        = r_char;
    assign o_last             = r_last;

endmodule

// ===== hdl/itpdt_checker.sv =====
// port-level checker of the decimal text block and its bind to the top level
// depends on int_to_padded_decimal_text_defines.svh
`include "int_to_padded_decimal_text_defines.svh"

module itpdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [4:0]  i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [31:0] i_value,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_char_code,
    input logic        o_last
);

    // a stalled character holds
    `ITPDT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_char_code) && $stable(o_last))

    // the input is still stalled when the conversion steps are done
    `ITPDT_ASSERT_IMP(a_busy_conv, i_clk, i_rst_n, i_in_valid && !o_in_stall, ##33 o_in_stall)

    // only blank, minus or a digit is produced
    `ITPDT_ASSERT_IMP(a_char_legal, i_clk, i_rst_n, o_out_valid, (o_char_code == 8'h20) || (o_char_code == 8'h2D) || ((o_char_code >= 8'h30) && (o_char_code <= 8'h39)))

    // text always ends on a digit
    `ITPDT_ASSERT_IMP(a_last_digit, i_clk, i_rst_n, o_out_valid && o_last, (o_char_code >= 8'h30) && (o_char_code <= 8'h39))

endmodule

bind int_to_padded_decimal_text itpdt_checker u_itpdt_checker (.*);

// ===== bench/testbench.sv =====
// testbench for int_to_padded_decimal_text: signed integer to padded decimal text
// depends on itpdt_pkg and the int_to_padded_decimal_text rtl; self-checking
`timescale 1ns / 1ps

module testbench;

    localparam int FIELD_MAX    = 16;
    localparam int HALF_PERIOD  = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 10;
    localparam int PER_PHASE    = 26;
    localparam int NUM_DIRECTED = 20;

    // one expected output character
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_text_char;

    // directed row: width to use, value, and text when it is obvious
    typedef struct {
        logic [4:0]  width;
        logic [31:0] value;
        string       text;
    } t_text_case;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [4:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [7:0]         o_char_code;
    logic               o_last;

    t_text_char  expected_chars[$];
    logic [4:0]  field_width;
    int          mismatches;
    int unsigned cycle_count;
    bit          quiet;
    bit          hold_req;
    t_text_case  directed_cases [NUM_DIRECTED];

    int_to_padded_decimal_text #(
        .MAX_WIDTH(FIELD_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // clock
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void push_char(input logic [7:0] ch, input logic fin);
        t_text_char c;
        c.ch  = ch;
        c.fin = fin;
        expected_chars.push_back(c);
    endfunction

    // expected characters of one value at the current field width
    function automatic void predict_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  dig [10];
        int          nd;
        int          text_len;
        int          fw;
        int          total;
        mag = v[31] ? (32'd0 - v) : v;
        nd  = 0;
        do begin
            dig[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 32'd0);
        text_len = nd + (v[31] ? 1 : 0);
        fw       = (field_width > FIELD_MAX) ? FIELD_MAX : int'(field_width);
        total    = (fw > text_len) ? fw : text_len;
        for (int i = 0; i < total - text_len; i++) begin
            push_char(itpdt_pkg::CH_BLANK, 1'b0);
        end
        if (v[31]) begin
            push_char(itpdt_pkg::CH_MINUS, 1'b0);
        end
        for (int d = nd - 1; d >= 0; d--) begin
            push_char(itpdt_pkg::CH_ZERO + 8'(dig[d]), d == 0);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                   input logic [7:0] act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s: expected %h, got %h at %0t", what, exp_v, act_v,
                     $time);
        end
    endtask

    // check each accepted character against the oldest expectation
    always @(posedge i_clk) begin : check_out
        t_text_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected character", 8'h00, o_char_code);
            end else begin
                want = expected_chars.pop_front();
                if (o_char_code !== want.ch) begin
                    report_mismatch("char_code", want.ch, o_char_code);
                end
                if (o_last !== want.fin) begin
                    report_mismatch("last", 8'(want.fin), 8'(o_last));
                end
            end
        end
    end

    // output stall bursts, one long hold-off, none in the quiet tail
    initial begin : out_stall_gen
        int run_len;
        bit hold_done;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                run_len = $urandom_range(1, 14);
                repeat (run_len - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                run_len = $urandom_range(1, 40);
                repeat (run_len - 1) @(negedge i_clk);
            end
        end
    end

    // offer one request; called and returns at a falling edge, valid left high
    task automatic send_value(input logic [31:0] v, input string text);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        if (text.len() == 0) begin
            predict_text(v);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                push_char(text[i], i == text.len() - 1);
            end
        end
        @(negedge i_clk);
    endtask

    // width change only once every character is out
    task automatic set_field_width(input logic [4:0] w);
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        field_width = w;
    endtask

    // random value: full range, short numbers, powers of ten, extremes
    function automatic logic [31:0] pick_value();
        logic [31:0] r;
        int unsigned p10;
        case ($urandom_range(0, 5))
            0, 1: r = $urandom();
            2: r = $urandom_range(0, 999);
            3: r = 32'd0 - $urandom_range(1, 999);
            4: begin
                p10 = 1;
                repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                r = p10 + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1) begin
                    r = 32'd0 - r;
                end
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: r = 32'h8000_0000;
                    1: r = 32'h7FFF_FFFF;
                    2: r = 32'h0000_0000;
                    default: r = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return r;
    endfunction

    initial begin : stimulus
        logic [4:0] w;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = 5'd0;
        i_in_valid  = 1'b0;
        i_value     = 32'sd0;
        field_width = 5'd0;
        mismatches  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;

        // zero width, extremes, digit count boundaries
        directed_cases[0]  = '{5'd0,  32'd0,          "0"};
        directed_cases[1]  = '{5'd0,  32'h7FFF_FFFF,  "2147483647"};
        directed_cases[2]  = '{5'd0,  32'h8000_0000,  "-2147483648"};
        directed_cases[3]  = '{5'd0,  32'hFFFF_FFFF,  "-1"};
        directed_cases[4]  = '{5'd0,  32'd9,          ""};
        directed_cases[5]  = '{5'd0,  32'd10,         ""};
        directed_cases[6]  = '{5'd0,  -32'sd10,       ""};
        directed_cases[7]  = '{5'd0,  32'd1000000000, ""};
        // full field width
        directed_cases[8]  = '{5'd16, 32'hFFFF_FFFF,  "              -1"};
        directed_cases[9]  = '{5'd16, 32'd0,          "               0"};
        directed_cases[10] = '{5'd16, 32'h8000_0000,  "     -2147483648"};
        // widths above the maximum saturate
        directed_cases[11] = '{5'd31, 32'd5,          "               5"};
        directed_cases[12] = '{5'd17, 32'd123,        ""};
        // width equal to and one above the longest text
        directed_cases[13] = '{5'd11, 32'h8000_0000,  "-2147483648"};
        directed_cases[14] = '{5'd11, 32'd7,          ""};
        directed_cases[15] = '{5'd12, 32'h8000_0000,  " -2147483648"};
        // narrow widths: equal to, shorter than and longer than the text
        directed_cases[16] = '{5'd1,  32'd0,          "0"};
        directed_cases[17] = '{5'd1,  -32'sd5,        ""};
        directed_cases[18] = '{5'd5,  32'd42,         "   42"};
        directed_cases[19] = '{5'd5,  -32'sd987654,   ""};

        // hold synchronous reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_field_width(5'd0);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_cases[i].width != field_width) begin
                set_field_width(directed_cases[i].width);
            end
            send_value(directed_cases[i].value, directed_cases[i].text);
        end

        // random phases, each at its own width
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: w = 5'd0;
                1: w = 5'd16;
                2: w = 5'd31;
                3: w = 5'd7;
                4: w = 5'd17;
                5: w = 5'd11;
                6: w = 5'd12;
                7: w = 5'd1;
                default: w = 5'($urandom_range(0, 31));
            endcase
            set_field_width(w);
            if (p == 2) begin
                hold_req = 1'b1;
            end
            if (p == NUM_PHASES - 1) begin
                quiet = 1'b1;
            end
            for (int n = 0; n < PER_PHASE; n++) begin
                send_value(pick_value(), "");
            end
        end

        // drain and watch for stray characters
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/itpdt_pkg.sv
hdl/itpdt_ctrl.sv
hdl/itpdt_dp.sv
hdl/int_to_padded_decimal_text.sv
hdl/itpdt_checker.sv
bench/testbench.sv
